// File: rtl/dcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DC removal package
// Shared widths, constants, operand select codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int SUM_BITS    = 64;
    localparam int COUNT_BITS  = 11;
    localparam int DEN_BITS    = 11;
    localparam int PROD_BITS   = 42;
    localparam int PHASE_BITS  = 2;
    localparam int ITER_BITS   = 6;

    localparam int CHUNK_BITS     = 16;
    localparam int CHUNK_CNT_BITS = 2;
    localparam int REM_BITS       = 10;
    localparam int WIN_BITS       = REM_BITS + CHUNK_BITS;
    localparam int RECIP_BITS     = 27;
    localparam int RPROD_BITS     = WIN_BITS + RECIP_BITS;
    localparam int DC_SHIFT       = 36;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PHASE_BITS-1:0] DECIM_LAST = PHASE_BITS'(2);
    localparam logic [DEN_BITS-1:0] DC_DEN = DEN_BITS'(1000);
    localparam logic signed [DEN_BITS-1:0] DC_KEEP = 11'sd999;

    // Rounded-up reciprocal of 1000 scaled by 2^DC_SHIFT, exact for windows
    // below 2^WIN_BITS.
    localparam logic [RECIP_BITS-1:0] DC_RECIP = RECIP_BITS'(68719477);

    // Divider operand selection.
    localparam logic [1:0] SEL_MEAN   = 2'd0;
    localparam logic [1:0] SEL_SCALE  = 2'd1;
    localparam logic [1:0] SEL_OFFSET = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       div_start;
        logic [1:0] div_sel;
        logic       save_q1;
        logic       update_offset;
    } dcr_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic upd_ok;
        logic div_done;
    } dcr_status_t;

endpackage

// File: rtl/dcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DC removal divider
// Signed 64-bit by unsigned 11-bit truncating divider, one quotient bit per
// cycle on magnitudes, with the sign restored at the output.
// ----------------------------------------------------------------------------
module dcr_div
    import dcr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0]        divisor,
    output logic                       done,
    output logic signed [SUM_BITS-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_BITS-1:0]  cnt_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [DEN_BITS-1:0]   rem_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic                  neg_reg;

    logic [SUM_BITS-1:0]   magnitude;
    logic [DEN_BITS:0]     rem_shift;
    logic [DEN_BITS:0]     rem_sub;
    logic                  fits;

    assign magnitude = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : dividend;
    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[SUM_BITS-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// File: rtl/dcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DC removal datapath
// Decimation phase, offset subtraction, block sum and count, output
// register and the block-end offset arithmetic around the mean divider and
// a divide-by-1000 unit built on reciprocal multiplication.
// ----------------------------------------------------------------------------
module dcr_datapath
    import dcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dcr_cmd_t               cmd,
    output dcr_status_t            status,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   block_last,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [SAMPLE_BITS-1:0] out_data
);

    logic                          enable_reg;
    logic [SAMPLE_BITS-1:0]        offset_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic [SAMPLE_BITS-1:0]        q1_reg;

    logic                          kdiv_busy_reg;
    logic                          kdiv_done_reg;
    logic                          kdiv_step_reg;
    logic [CHUNK_CNT_BITS-1:0]     kdiv_cnt_reg;
    logic [SUM_BITS-1:0]           kdiv_num_reg;
    logic [SUM_BITS-1:0]           kdiv_quo_reg;
    logic [REM_BITS-1:0]           kdiv_rem_reg;
    logic                          kdiv_neg_reg;
    logic [RPROD_BITS-1:0]         kdiv_prod_reg;

    logic signed [PROD_BITS:0]     prod_full;
    logic                          mean_start;
    logic                          mean_done;
    logic signed [SUM_BITS-1:0]    mean_q;

    logic                          kdiv_start;
    logic signed [SUM_BITS-1:0]    kdiv_dividend;
    logic [SUM_BITS-1:0]           kdiv_mag;
    logic [WIN_BITS-1:0]           kdiv_win;
    logic [RPROD_BITS-1:0]         kdiv_prod_full;
    logic [CHUNK_BITS-1:0]         kdiv_digit;
    logic [WIN_BITS-1:0]           kdiv_back;
    logic [WIN_BITS-1:0]           kdiv_rem_full;
    logic signed [SUM_BITS-1:0]    kdiv_q;

    assign prod_full = $signed(offset_reg) * DC_KEEP;

    assign mean_start    = cmd.div_start && (cmd.div_sel == SEL_MEAN);
    assign kdiv_start    = cmd.div_start && (cmd.div_sel != SEL_MEAN);
    assign kdiv_dividend = (cmd.div_sel == SEL_SCALE) ? mean_q : SUM_BITS'(prod_reg);

    dcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mean_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (mean_done),
        .quotient (mean_q)
    );

    // Division by 1000 on the magnitude, one 16-bit digit at a time, each by
    // a reciprocal multiply, then the remainder fix-up.
    assign kdiv_mag       = kdiv_dividend[SUM_BITS-1] ? SUM_BITS'(-kdiv_dividend)
                                                      : kdiv_dividend;
    assign kdiv_win       = {kdiv_rem_reg, kdiv_num_reg[SUM_BITS-1 -: CHUNK_BITS]};
    assign kdiv_prod_full = RPROD_BITS'(kdiv_win) * RPROD_BITS'(DC_RECIP);
    assign kdiv_digit     = kdiv_prod_reg[DC_SHIFT +: CHUNK_BITS];
    assign kdiv_back      = WIN_BITS'(kdiv_digit) * WIN_BITS'(DC_DEN);
    assign kdiv_rem_full  = kdiv_win - kdiv_back;
    assign kdiv_q         = kdiv_neg_reg ? -$signed(kdiv_quo_reg) : $signed(kdiv_quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kdiv_busy_reg <= 1'b0;
            kdiv_done_reg <= 1'b0;
            kdiv_step_reg <= 1'b0;
            kdiv_cnt_reg  <= '0;
        end else begin
            kdiv_done_reg <= 1'b0;
            if (kdiv_start) begin
                kdiv_busy_reg <= 1'b1;
                kdiv_step_reg <= 1'b0;
                kdiv_cnt_reg  <= '0;
            end else if (kdiv_busy_reg) begin
                kdiv_step_reg <= !kdiv_step_reg;
                if (kdiv_step_reg) begin
                    kdiv_cnt_reg <= kdiv_cnt_reg + 1'b1;
                    if (kdiv_cnt_reg == '1) begin
                        kdiv_busy_reg <= 1'b0;
                        kdiv_done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (kdiv_start) begin
            kdiv_num_reg <= kdiv_mag;
            kdiv_quo_reg <= '0;
            kdiv_rem_reg <= '0;
            kdiv_neg_reg <= kdiv_dividend[SUM_BITS-1];
        end else if (kdiv_busy_reg) begin
            if (!kdiv_step_reg) begin
                kdiv_prod_reg <= kdiv_prod_full;
            end else begin
                kdiv_num_reg <= {kdiv_num_reg[SUM_BITS-CHUNK_BITS-1:0], {CHUNK_BITS{1'b0}}};
                kdiv_quo_reg <= {kdiv_quo_reg[SUM_BITS-CHUNK_BITS-1:0], kdiv_digit};
                kdiv_rem_reg <= kdiv_rem_full[REM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            offset_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                if (phase_reg == '0) begin
                    out_valid_reg <= 1'b1;
                    if (enable_reg) begin
                        sum_reg <= sum_reg + SUM_BITS'($signed(sample_in));
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end else if (out_ready) begin
                    out_valid_reg <= 1'b0;
                end
                if (block_last || phase_reg == DECIM_LAST) begin
                    phase_reg <= '0;
                end else begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.update_offset) begin
                offset_reg <= q1_reg + kdiv_q[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[PROD_BITS-1:0];
        if (cmd.accept && phase_reg == '0) begin
            out_data_reg <= enable_reg ? sample_in - offset_reg : sample_in;
        end
        if (cmd.save_q1) begin
            q1_reg <= kdiv_q[SAMPLE_BITS-1:0];
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.upd_ok    = enable_reg && (count_reg != '0);
    assign status.div_done  = mean_done || kdiv_done_reg;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

// File: rtl/dcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DC removal controller
// Sample acceptance and the block-end sequence that, when an update is allowed,
// runs three divisions to produce the new offset.
// ----------------------------------------------------------------------------
module dcr_ctrl
    import dcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  logic        out_ready,
    input  dcr_status_t status,
    output dcr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_END    = 3'd1;
    localparam logic [2:0] ST_MEAN   = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_OFFSET = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready   = !status.out_valid || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept && in_last) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                cmd.clear = 1'b1;
                if (status.upd_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_MEAN;
                    state_next    = ST_MEAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEAN: begin
                cmd.div_sel = SEL_SCALE;
                if (status.div_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.div_sel = SEL_OFFSET;
                if (status.div_done) begin
                    cmd.save_q1   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                cmd.div_sel = SEL_OFFSET;
                if (status.div_done) begin
                    cmd.update_offset = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/decimate_and_dc_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimate-by-three with block-mean DC offset removal
// Keeps every third raw sample of each block, subtracts the tracked offset
// when correction is enabled, and refreshes the offset at each block end.
//
// The slave stream carries one raw sample per transaction, with tlast on the
// final sample of a block. The master stream carries one kept sample per
// transaction. cfg_we writes the correction enable bit from cfg_wdata.
// Within a block one raw sample is taken per cycle while the master side
// does not stall; a kept sample appears on the master side in the cycle
// after its transaction. After a tlast transaction the block closes and
// clears the sum and count and, when correction is on and samples were
// counted, runs a division for the mean on the one-bit-per-cycle divider and
// two divisions by 1000 by reciprocal multiplication before s_tready rises.
// A stalled master side holds the pending sample in the output register; a
// new raw sample is taken only when that register is free or drains in the
// same cycle. Reset clears the offset, the sum, the count, the phase, the
// enable bit and the output valid.
// ----------------------------------------------------------------------------
module decimate_and_dc_remove
    import dcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_in
    input  logic        s_tlast,   // block_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sample_out
    input  logic        cfg_we,
    input  logic        cfg_wdata  // correction_enable
);

    dcr_cmd_t    cmd;
    dcr_status_t status;

    dcr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dcr_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (s_tdata),
        .block_last (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule

// File: bench/decimate_and_dc_remove_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimate and DC remove testbench
// Drives raw samples in blocks over the slave stream and checks every kept
// sample on the master stream against a cycle-free model of the decimation
// and block-mean offset tracking. A short directed table covers extremes,
// the pass-through mode, odd block lengths and toggling of the correction
// bit. Random blocks with a per-block DC bias follow, then one longer block
// with a steady bias. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module decimate_and_dc_remove_test;

    localparam int           RAND_ITEMS  = 1320;
    localparam int           LONG_BLOCK  = 600;
    localparam int           SETTLE      = 260;
    localparam int           HOLD_CYCLES = 500;
    localparam int           LIMIT       = 2000000;
    localparam int           DIR_ROWS    = 27;
    localparam longint       DEN         = 1000;
    localparam longint       KEEP        = 999;
    localparam logic [10:0]  COUNT_SAT   = 11'd2047;

    typedef enum logic [1:0] {CFG_KEEP, CFG_OFF, CFG_ON} cfg_action_e;

    typedef struct packed {
        cfg_action_e action;
        logic [31:0] sample;
        logic        last;
        logic        typed;
        logic [31:0] want;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] sample_in
    logic        s_tlast   = 1'b0; // block_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] sample_out
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0; // correction_enable

    logic               mdl_enable = 1'b0;
    logic signed [31:0] mdl_offset = '0;
    logic        [63:0] mdl_sum    = '0;
    logic        [10:0] mdl_count  = '0;
    logic         [1:0] mdl_phase  = '0;

    logic [31:0] out_expected [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;
    dir_row_t    dir_tab [DIR_ROWS];

    decimate_and_dc_remove dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic dc_model_step(input logic [31:0] raw, input logic last,
                                 output logic kept, output logic [31:0] res);
        longint mean;
        longint nxt;
        kept = (mdl_phase == 2'd0);
        res  = raw;
        if (kept && mdl_enable) begin
            res     = raw - mdl_offset;
            mdl_sum = mdl_sum + {{32{raw[31]}}, raw};
            if (mdl_count != COUNT_SAT) begin
                mdl_count = mdl_count + 11'd1;
            end
        end
        mdl_phase = (mdl_phase == 2'd2) ? 2'd0 : mdl_phase + 2'd1;
        if (last) begin
            if (mdl_enable && mdl_count != 11'd0) begin
                mean = longint'($signed(mdl_sum)) / longint'({53'd0, mdl_count});
                nxt  = mean / DEN + (KEEP * longint'(mdl_offset)) / DEN;
                mdl_offset = nxt[31:0];
            end
            mdl_sum   = '0;
            mdl_count = '0;
            mdl_phase = '0;
        end
    endtask

    task automatic send_sample(input logic [31:0] d, input logic l, input bit gappy,
                               input bit typed, input logic [31:0] typed_val);
        int          gap;
        logic        kept;
        logic [31:0] res;
        gap = gappy ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        dc_model_step(d, l, kept, res);
        if (kept) begin
            out_expected.push_back(typed ? typed_val : res);
        end
    endtask

    // The register is only written once the block has drained and any
    // block-end division has had time to finish.
    task automatic write_enable(input logic v);
        s_tvalid <= 1'b0;
        while (out_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        mdl_enable  = v;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (out_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected sample_out %h", m_tdata));
            end else begin
                if (m_tdata !== out_expected[0]) begin
                    report_mismatch($sformatf("sample_out %h, predicted %h",
                                              m_tdata, out_expected[0]));
                end
                void'(out_expected.pop_front());
            end
        end
    end

    initial begin
        int run;
        int idle;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                run = $urandom_range(1, 40);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                idle = pick_gap();
                if (idle != 0) begin
                    m_tready <= 1'b0;
                    repeat (idle) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("decimate_and_dc_remove_test: FAIL");
        $finish;
    end

    initial begin
        int                 sent;
        int                 len;
        int                 toggle_at;
        int                 r;
        bit                 gappy;
        bit                 mid_done;
        bit                 late_done;
        logic signed [31:0] bias;
        logic        [31:0] smp;

        dir_tab = '{
            '{CFG_KEEP, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
            '{CFG_KEEP, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{CFG_KEEP, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
            '{CFG_ON,   32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{CFG_KEEP, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{CFG_KEEP, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h0000_0004, 1'b1, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'h0000_0006, 1'b1, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd100,       1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd200,       1'b1, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd300,       1'b1, 1'b0, 32'h0},
            '{CFG_OFF,  32'd5,         1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd6,         1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd7,         1'b0, 1'b0, 32'h0},
            '{CFG_ON,   32'd8,         1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd9,         1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd10,        1'b1, 1'b0, 32'h0},
            '{CFG_OFF,  32'd11,        1'b0, 1'b0, 32'h0},
            '{CFG_ON,   32'd12,        1'b0, 1'b0, 32'h0},
            '{CFG_KEEP, 32'd13,        1'b1, 1'b0, 32'h0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].action == CFG_OFF) begin
                write_enable(1'b0);
            end else if (dir_tab[i].action == CFG_ON) begin
                write_enable(1'b1);
            end
            send_sample(dir_tab[i].sample, dir_tab[i].last, 1'b1,
                        dir_tab[i].typed, dir_tab[i].want);
        end

        sent      = 0;
        mid_done  = 1'b0;
        late_done = 1'b0;
        while (sent < RAND_ITEMS) begin
            if (!mid_done && sent >= 700) begin
                write_enable(1'b0);
                mid_done = 1'b1;
            end
            if (!late_done && sent >= 1000) begin
                write_enable(1'b1);
                late_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                len = 3 * $urandom_range(60, 150);
            end else if (r < 85) begin
                len = 3 * $urandom_range(1, 12);
            end else begin
                len = $urandom_range(1, 20);
            end
            if ($urandom_range(0, 3) == 0) begin
                bias = $urandom;
            end else begin
                bias = $signed($urandom) >>> $urandom_range(8, 30);
            end
            gappy     = ($urandom_range(0, 9) < 7);
            toggle_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                if (k == toggle_at) begin
                    write_enable(!mdl_enable);
                end
                if (sent == 1100) begin
                    hold_req = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    case ($urandom_range(0, 3))
                        0: smp = 32'h8000_0000;
                        1: smp = 32'h7FFF_FFFF;
                        2: smp = 32'h0000_0000;
                        default: smp = 32'hFFFF_FFFF;
                    endcase
                end else if (r < 25) begin
                    smp = $urandom;
                end else begin
                    smp = bias + 32'($urandom_range(0, 2047)) - 32'd1024;
                end
                send_sample(smp, (k == len - 1), gappy, 1'b0, 32'h0);
                sent++;
            end
        end

        // One longer block with a steady bias ends the run.
        if (!mdl_enable) begin
            write_enable(1'b1);
        end
        bias = $signed($urandom) >>> 4;
        for (int k = 0; k < LONG_BLOCK; k++) begin
            smp = bias + 32'($urandom_range(0, 65535)) - 32'd32768;
            send_sample(smp, (k == LONG_BLOCK - 1), 1'b0, 1'b0, 32'h0);
        end

        s_tvalid <= 1'b0;
        while (out_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("decimate_and_dc_remove_test: PASS");
        end else begin
            $display("decimate_and_dc_remove_test: FAIL");
        end
        $finish;
    end

endmodule
